// ----- design/pidc_pkg.sv -----
// Shared types, constants and the symmetric clamp for the PID step block.
// No dependencies; imported by pidc_mul and pid_step_with_clamps.
package pidc_pkg;

  localparam int ErrW   = 16;
  localparam int GainW  = 16;
  localparam int CmdW   = 16;
  localparam int PrdW   = ErrW + GainW;      // kp*e, ki*e
  localparam int DifW   = ErrW + 1;          // e - previous_error
  localparam int DprW   = DifW + GainW;      // kd*(e - prev)
  localparam int AccW   = DprW + 2;          // full-width command sum
  localparam int TdInW  = 16;
  localparam int TdOutW = 24;

  localparam logic signed [AccW-1:0] SatPos = AccW'(32767);
  localparam logic signed [AccW-1:0] SatNeg = -AccW'(32767);

  typedef enum logic [1:0] {
    CFG_KP = 2'd0,
    CFG_KI = 2'd1,
    CFG_KD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                   clear;
    logic signed [PrdW-1:0] p_kp;
    logic signed [PrdW-1:0] p_ki;
    logic signed [DprW-1:0] p_kd;
  } prod_t;

  typedef struct packed {
    logic                   hit;
    logic signed [CmdW-1:0] val;
  } sat_t;

  function automatic sat_t clamp_sym(input logic signed [AccW-1:0] v);
    sat_t r;
    if (v > SatPos) begin
      r.hit = 1'b1;
      r.val = SatPos[CmdW-1:0];
    end else if (v < SatNeg) begin
      r.hit = 1'b1;
      r.val = SatNeg[CmdW-1:0];
    end else begin
      r.hit = 1'b0;
      r.val = v[CmdW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/pidc_mul.sv -----
// Input stage: forms kp*e, ki*e and kd*(e - previous_error) and registers them.
// Keeps previous_error. Depends on pidc_pkg.
module pidc_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           clear_i,
  input  logic signed [pidc_pkg::ErrW-1:0]  error_i,
  input  logic signed [pidc_pkg::GainW-1:0] kp_i,
  input  logic signed [pidc_pkg::GainW-1:0] ki_i,
  input  logic signed [pidc_pkg::GainW-1:0] kd_i,
  output pidc_pkg::prod_t                prod_o
);
  import pidc_pkg::*;

  logic signed [ErrW-1:0] prev_q, prev_d;
  logic signed [DifW-1:0] diff;
  prod_t                  prod_q, prod_d;

  always_comb begin
    diff = {error_i[ErrW-1], error_i} - {prev_q[ErrW-1], prev_q};
    prod_d.clear = clear_i;
    prod_d.p_kp  = {{(PrdW-GainW){kp_i[GainW-1]}}, kp_i}
                 * {{(PrdW-ErrW){error_i[ErrW-1]}}, error_i};
    prod_d.p_ki  = {{(PrdW-GainW){ki_i[GainW-1]}}, ki_i}
                 * {{(PrdW-ErrW){error_i[ErrW-1]}}, error_i};
    prod_d.p_kd  = {{(DprW-GainW){kd_i[GainW-1]}}, kd_i}
                 * {{(DprW-DifW){diff[DifW-1]}}, diff};
    prev_d = clear_i ? '0 : error_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (load_i) begin
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- design/pid_step_with_clamps.sv -----
// PID controller step with integrator and output clamps, top level.
// Instantiates pidc_mul; depends on pidc_pkg.
//
// Usage:
//   Input stream (s_axis): tuser = action (1 = clear, 0 = step), tdata = error.
//   Output stream (m_axis): tdata = command, integral_saturated,
//   output_saturated. Exactly one output transaction per input transaction,
//   in order.
//   Gains kp, ki, kd are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   (index 0, 1, 2; index 3 ignored) while the block is idle.
// Timing:
//   Two-stage pipeline: the multipliers feed a product register, then the
//   integrator add, clamp, command sum and clamp feed the output register.
//   Input passes the product, then the output register; with m_axis_tready_i
//   high one transaction per cycle is sustained. The integrator register
//   closes its loop in the second stage, so consecutive steps need no gap.
// Reset:
//   Gains, integral and previous error clear to zero; both streams empty.
// Backpressure:
//   While m_axis_tready_i is low with a result held, the product register
//   still fills once, then s_axis_tready_o drops until the result is taken.
module pid_step_with_clamps (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [pidc_pkg::GainW-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [pidc_pkg::TdInW-1:0]    s_axis_tdata_i,   // [15:0] error
  input  logic                          s_axis_tuser_i,   // [0] action
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] command, [16] integral_saturated, [17] output_saturated, [23:18] zero
  output logic [pidc_pkg::TdOutW-1:0]   m_axis_tdata_o
);
  import pidc_pkg::*;

  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic                    in_acc;
  logic                    adv;
  logic                    s1_vld_q, s1_vld_d;
  logic                    out_vld_q, out_vld_d;
  prod_t                   prod;
  logic signed [CmdW-1:0]  integ_q, integ_d;
  logic signed [AccW-1:0]  acc_sum;
  logic signed [AccW-1:0]  cmd_sum;
  sat_t                    isat;
  sat_t                    osat;
  logic signed [CmdW-1:0]  cmd_q, cmd_d;
  logic                    isat_q, isat_d;
  logic                    osat_q, osat_d;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KP:  kp_q <= cfg_data_i;
        CFG_KI:  ki_q <= cfg_data_i;
        CFG_KD:  kd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv             = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  pidc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .clear_i (s_axis_tuser_i),
    .error_i (s_axis_tdata_i[ErrW-1:0]),
    .kp_i    (kp_q),
    .ki_i    (ki_q),
    .kd_i    (kd_q),
    .prod_o  (prod)
  );

  always_comb begin
    acc_sum = {{(AccW-CmdW){integ_q[CmdW-1]}}, integ_q}
            + {{(AccW-PrdW){prod.p_ki[PrdW-1]}}, prod.p_ki};
    isat    = clamp_sym(acc_sum);
    cmd_sum = {{(AccW-PrdW){prod.p_kp[PrdW-1]}}, prod.p_kp}
            + {{(AccW-CmdW){isat.val[CmdW-1]}}, isat.val}
            + {{(AccW-DprW){prod.p_kd[DprW-1]}}, prod.p_kd};
    osat    = clamp_sym(cmd_sum);
    if (prod.clear) begin
      integ_d = '0;
      cmd_d   = '0;
      isat_d  = 1'b0;
      osat_d  = 1'b0;
    end else begin
      integ_d = isat.val;
      cmd_d   = osat.val;
      isat_d  = isat.hit;
      osat_d  = osat.hit;
    end
    s1_vld_d  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_vld_q);
    out_vld_d = adv ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      integ_q   <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q  <= cmd_d;
      isat_q <= isat_d;
      osat_q <= osat_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(TdOutW-CmdW-2)'(0), osat_q, isat_q, cmd_q};

`ifndef SYNTHESIS
  a_integ_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q != {1'b1, {(CmdW-1){1'b0}}})
    else $error("integral reached negative full scale");

  a_cmd_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (cmd_q != {1'b1, {(CmdW-1){1'b0}}}))
    else $error("command reached negative full scale");

  a_osat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && osat_q) |-> (cmd_q == CmdW'(32767) || cmd_q == -CmdW'(32767)))
    else $error("output saturation flag without command at a rail");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && prod.clear) |=> (integ_q == '0 && cmd_q == '0 && !isat_q && !osat_q))
    else $error("clear did not zero integral and result");
`endif

endmodule
